// ===== rtl/bft_pkg.sv =====
// ----------------------------------------------------------------------------
// bft_pkg
// Shared widths, register indexes and helpers for the foot trajectory block.
// ----------------------------------------------------------------------------
package bft_pkg;

  // field widths
  localparam int LEN_W     = 24;
  localparam int PHASE_W   = 16;
  localparam int ROLL_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int SIN_W     = 17;

  // default depth of the quarter-wave sine table
  localparam int SINE_ENTRIES_DEFAULT = 1024;

  // pi/2 in Q30, seed of the table series
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // series divisors (2k)(2k+1)
  localparam logic [63:0] TAYLOR_DIV [1:39] = '{
    64'd6,    64'd20,   64'd42,   64'd72,   64'd110,  64'd156,  64'd210,  64'd272,
    64'd342,  64'd420,  64'd506,  64'd600,  64'd702,  64'd812,  64'd930,  64'd1056,
    64'd1190, 64'd1332, 64'd1482, 64'd1640, 64'd1806, 64'd1980, 64'd2162, 64'd2352,
    64'd2550, 64'd2756, 64'd2970, 64'd3192, 64'd3422, 64'd3660, 64'd3906, 64'd4160,
    64'd4422, 64'd4692, 64'd4970, 64'd5256, 64'd5550, 64'd5852, 64'd6162
  };

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIFT_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STANCE_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_CAP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWAY_AMPLITUDE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEG_SPACING    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FOOT_ROLL      = 3'd6;

  // saturate a wide signed value to a length field
  function automatic logic signed [LEN_W-1:0] sat_len(input logic signed [47:0] v);
    logic signed [LEN_W-1:0] r;
    if (v > 48'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -48'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[LEN_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/biped_foot_trajectory_generator.sv =====
// ----------------------------------------------------------------------------
// biped_foot_trajectory_generator
// Foot x, y, z targets for both feet of a biped from one gait phase sample.
// The block takes one phase request per clock unless the output is held, and
// delivers its result through a five-rank pipeline (input register, sine index,
// sine ROM read with the stride multiplies, lift and sway multiplies, output
// register). The whole pipeline advances together whenever the output register
// is empty or its result is taken, so a held output stalls every rank and
// nothing is lost or repeated. One quarter-wave sine ROM of
// SINE_TABLE_ENTRIES+1 entries with a registered read serves the swing lift
// and the lateral sway; the right foot trails the left by half the phase range.
// Configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module biped_foot_trajectory_generator import bft_pkg::*; #(
  parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [LEN_W-1:0]            cfg_data,
  // phase requests
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [PHASE_W-1:0]          phase,
  // results
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [LEN_W-1:0]     left_x,
  output logic signed [LEN_W-1:0]     left_y,
  output logic signed [LEN_W-1:0]     left_z,
  output logic signed [LEN_W-1:0]     right_x,
  output logic signed [LEN_W-1:0]     right_y,
  output logic signed [LEN_W-1:0]     right_z,
  output logic signed [ROLL_W-1:0]    roll_out
);

  localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);

  typedef logic [SIN_W-1:0] rom_t [SINE_TABLE_ENTRIES+1];

  // quarter-wave sine in Q16, built by its Taylor series
  function automatic rom_t build_rom();
    rom_t                rom;
    logic [63:0]         x;
    logic [63:0]         term;
    logic signed [63:0]  sum;
    logic                neg;
    for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_ENTRIES;
      term = x;
      sum  = '0;
      neg  = 1'b0;
      for (int k = 1; k < 40; k++) begin
        if (term != 64'd0) begin
          sum  = neg ? sum - $signed(term) : sum + $signed(term);
          neg  = !neg;
          term = (term * x) >> 30;
          term = (term * x) >> 30;
          term = term / TAYLOR_DIV[k];
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      rom[i] = SIN_W'((sum + 64'sd8192) >>> 14);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  localparam logic signed [PHASE_W:0] STANCE_MID = 17'sd16384;
  localparam logic signed [PHASE_W:0] SWING_MID  = 17'sd49152;

  // configuration registers
  logic signed [LEN_W-1:0]  step_length;
  logic signed [LEN_W-1:0]  lift_height;
  logic signed [LEN_W-1:0]  stance_height;
  logic signed [LEN_W-1:0]  height_cap;
  logic signed [LEN_W-1:0]  sway_amplitude;
  logic signed [LEN_W-1:0]  leg_spacing;
  logic signed [ROLL_W-1:0] foot_roll;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_length    <= '0;
      lift_height    <= '0;
      stance_height  <= '0;
      height_cap     <= '0;
      sway_amplitude <= '0;
      leg_spacing    <= '0;
      foot_roll      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STEP_LENGTH:    step_length    <= cfg_data;
        REG_LIFT_HEIGHT:    lift_height    <= cfg_data;
        REG_STANCE_HEIGHT:  stance_height  <= cfg_data;
        REG_HEIGHT_CAP:     height_cap     <= cfg_data;
        REG_SWAY_AMPLITUDE: sway_amplitude <= cfg_data;
        REG_LEG_SPACING:    leg_spacing    <= cfg_data;
        REG_FOOT_ROLL:      foot_roll      <= cfg_data[ROLL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: output empty or being taken
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // valid bits
  logic s1_valid, s2_valid, s3_valid, s4_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  // rank 1: input register
  logic [PHASE_W-1:0] s1_phase;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_phase <= phase;
    end
  end

  // rank 2: sine index and stride factors
  logic [14:0]             fold;
  logic [31:0]             idx_scaled;
  logic [31:0]             idx_full;
  logic [IDX_W-1:0]        idx;
  logic [PHASE_W-1:0]      right_phase;
  logic signed [PHASE_W:0] left_h;
  logic signed [PHASE_W:0] right_h;
  logic signed [PHASE_W:0] left_fac;
  logic signed [PHASE_W:0] right_fac;

  always_comb begin
    // mirror into the first quarter of the half wave
    fold = (s1_phase[14:0] > 15'd16384) ? 15'(16'd32768 - {1'b0, s1_phase[14:0]})
                                        : s1_phase[14:0];
    idx_scaled = 32'(fold) * 32'(SINE_TABLE_ENTRIES);
    idx_full   = (idx_scaled + 32'd8192) >> 14;
    if (idx_full > 32'(SINE_TABLE_ENTRIES)) begin
      idx = IDX_W'(SINE_TABLE_ENTRIES);
    end else begin
      idx = idx_full[IDX_W-1:0];
    end
    // right foot offset from the left by half the phase range
    right_phase = {~s1_phase[15], s1_phase[14:0]};
    left_h      = $signed({1'b0, s1_phase});
    right_h     = $signed({1'b0, right_phase});
    left_fac    = s1_phase[15]    ? left_h - SWING_MID  : STANCE_MID - left_h;
    right_fac   = right_phase[15] ? right_h - SWING_MID : STANCE_MID - right_h;
  end

  logic [IDX_W-1:0]        s2_idx;
  logic signed [PHASE_W:0] s2_left_fac;
  logic signed [PHASE_W:0] s2_right_fac;
  logic                    s2_neg;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_idx       <= idx;
      s2_left_fac  <= left_fac;
      s2_right_fac <= right_fac;
      s2_neg       <= s1_phase[15];
    end
  end

  // rank 3: sine ROM read and stride products
  logic [SIN_W-1:0]           s3_sin;
  logic signed [LEN_W+16:0]   s3_left_prod;
  logic signed [LEN_W+16:0]   s3_right_prod;
  logic                       s3_neg;

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_sin        <= SINE_ROM[s2_idx];
      s3_left_prod  <= step_length * s2_left_fac;
      s3_right_prod <= step_length * s2_right_fac;
      s3_neg        <= s2_neg;
    end
  end

  // rank 4: stride rounding, lift and sway products
  logic signed [SIN_W:0]      sin_mag;
  logic signed [SIN_W:0]      sin_signed;
  logic signed [LEN_W-1:0]    lift_lim;
  logic signed [LEN_W+16:0]   left_x_r;
  logic signed [LEN_W+16:0]   right_x_r;

  always_comb begin
    sin_mag    = $signed({1'b0, s3_sin});
    sin_signed = s3_neg ? -sin_mag : sin_mag;
    lift_lim   = (lift_height < height_cap) ? lift_height : height_cap;
    left_x_r   = (s3_left_prod + 41'sd16384) >>> 15;
    right_x_r  = (s3_right_prod + 41'sd16384) >>> 15;
  end

  logic signed [LEN_W-1:0]    s4_left_x;
  logic signed [LEN_W-1:0]    s4_right_x;
  logic signed [LEN_W+17:0]   s4_lift_prod;
  logic signed [LEN_W+17:0]   s4_sway_prod;
  logic                       s4_neg;

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_left_x    <= sat_len(48'(left_x_r));
      s4_right_x   <= sat_len(48'(right_x_r));
      s4_lift_prod <= lift_lim * sin_mag;
      s4_sway_prod <= sway_amplitude * sin_signed;
      s4_neg       <= s3_neg;
    end
  end

  // rank 5: swing height, lateral offsets, output register
  logic signed [LEN_W+17:0]   lift_r;
  logic signed [LEN_W+17:0]   sway_r;
  logic signed [47:0]         swing_sum;
  logic signed [47:0]         swing_capped;
  logic signed [47:0]         half_spacing;
  logic signed [LEN_W-1:0]    swing_z;

  always_comb begin
    lift_r       = (s4_lift_prod + 42'sd32768) >>> 16;
    sway_r       = (s4_sway_prod + 42'sd32768) >>> 16;
    swing_sum    = 48'(stance_height) + 48'(lift_r);
    swing_capped = (swing_sum > 48'(height_cap)) ? 48'(height_cap) : swing_sum;
    swing_z      = sat_len(swing_capped);
    half_spacing = 48'(leg_spacing) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      left_x   <= s4_left_x;
      right_x  <= s4_right_x;
      // left foot swings in the second half, right foot in the first
      left_z   <= s4_neg ? swing_z : stance_height;
      right_z  <= s4_neg ? stance_height : swing_z;
      left_y   <= sat_len(half_spacing - 48'(sway_r));
      right_y  <= sat_len(-half_spacing - 48'(sway_r));
      roll_out <= foot_roll;
    end
  end

endmodule

// ===== rtl/bft_checker.sv =====
// ----------------------------------------------------------------------------
// bft_checker
// Port-level checks for the foot trajectory block, bound to the top level.
// ----------------------------------------------------------------------------
module bft_checker import bft_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     cfg_write,
  input logic [CFG_IDX_W-1:0]     cfg_index,
  input logic [LEN_W-1:0]         cfg_data,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [LEN_W-1:0]  left_x,
  input logic signed [LEN_W-1:0]  left_y,
  input logic signed [LEN_W-1:0]  left_z,
  input logic signed [LEN_W-1:0]  right_x,
  input logic signed [LEN_W-1:0]  right_y,
  input logic signed [LEN_W-1:0]  right_z,
  input logic signed [ROLL_W-1:0] roll_out
);

  // shadow copies of the registers the results must echo
  logic [LEN_W-1:0]  stance_shadow;
  logic [ROLL_W-1:0] roll_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      stance_shadow <= '0;
      roll_shadow   <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_STANCE_HEIGHT) begin
        stance_shadow <= cfg_data;
      end
      if (cfg_index == REG_FOOT_ROLL) begin
        roll_shadow <= cfg_data[ROLL_W-1:0];
      end
    end
  end

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_x) && $stable(left_y) &&
      $stable(left_z) && $stable(right_x) && $stable(right_y) && $stable(right_z))
    else $error("result changed while stalled");

  // a request under a free output shows up after the pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready ##1 out_ready
      ##1 out_ready |=> out_valid)
    else $error("result missing after pipeline depth");

  // one foot is always in stance
  a_stance: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_z == $signed(stance_shadow)) || (right_z == $signed(stance_shadow)))
    else $error("neither foot at stance height");

  // roll is passed through
  a_roll: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> roll_out == $signed(roll_shadow))
    else $error("roll does not match its register");

endmodule

bind biped_foot_trajectory_generator bft_checker u_bft_checker (.*);
